>>> sv/mwe_pkg.sv
package mwe_pkg;

   // Width of the wait registers and of the settle counter.
   localparam int WAIT_BITS = 8;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_BITS = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SETTLE_TICKS     = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WRITE_WAIT_TICKS = 8'd1;

   // Register values after reset.
   localparam logic [WAIT_BITS-1:0] SETTLE_TICKS_RESET     = 8'd1;
   localparam logic [WAIT_BITS-1:0] WRITE_WAIT_TICKS_RESET = 8'd15;

   // Start bit and opcode that open each frame.
   localparam logic [2:0] HDR_READ  = 3'b110;
   localparam logic [2:0] HDR_WRITE = 3'b101;
   localparam logic [2:0] HDR_EWXX  = 3'b100;

   // Extra opcode bits that tell write enable from write disable.
   localparam logic [1:0] EWEN_SUBCODE = 2'b11;

   // Number of flag bits at the bottom of a result beat.
   localparam int RSP_FLAG_BITS = 6;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_EWEN  = 2'd2,
      OP_EWDS  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SHIFT  = 3'b010,
      PH_SETTLE = 3'b100
   } phase_type;

   // Classified item as it sits in the queue, next to its frame word.
   typedef struct packed {
      item_kind_type kind;
      op_type        op;
      logic          miso;
   } ctl_type;

   // Wait registers as seen by the sequencer.
   typedef struct packed {
      logic [WAIT_BITS-1:0] settle_ticks;
      logic [WAIT_BITS-1:0] write_wait_ticks;
   } cfg_type;

   // Result flags, chip_select in the lowest bit.
   typedef struct packed {
      logic rdata_valid;
      logic refused;
      logic busy_res;
      logic clock_pulse;
      logic mosi;
      logic chip_select;
   } rsp_flags_type;

endpackage

>>> sv/mwe_front.sv
module mwe_front
   import mwe_pkg::*;
#(
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: op, addr, wdata, miso, zero fill.
   input  logic [((3 + ADDR_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0 up: cmd.
   input  logic req_tuser,
   output logic q_valid,
   input  logic q_ready,
   output ctl_type q_ctl,
   output logic [3 + ADDR_BITS + DATA_BITS - 1:0] q_frame
);

   localparam int FRAME_BITS = 3 + ADDR_BITS + DATA_BITS;
   localparam int WDATA_LSB  = 2 + ADDR_BITS;
   localparam int MISO_BIT   = 2 + ADDR_BITS + DATA_BITS;

   ctl_type                 dec_ctl;
   logic [FRAME_BITS-1:0]   dec_frame;
   logic [ADDR_BITS-1:0]    dec_addr;
   logic [DATA_BITS-1:0]    dec_wdata;

   ctl_type                 ctl_ff   [2];
   logic [FRAME_BITS-1:0]   frame_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    push, pop;

   // Classify the beat and build the serial frame, left aligned.
   assign dec_addr  = req_tdata[2 +: ADDR_BITS];
   assign dec_wdata = req_tdata[WDATA_LSB +: DATA_BITS];

   always_comb begin
      dec_ctl.kind = item_kind_type'(req_tuser);
      dec_ctl.op   = op_type'(req_tdata[1:0]);
      dec_ctl.miso = req_tdata[MISO_BIT];
      unique case (dec_ctl.op)
         OP_READ:  dec_frame = {HDR_READ, dec_addr, {DATA_BITS{1'b0}}};
         OP_WRITE: dec_frame = {HDR_WRITE, dec_addr, dec_wdata};
         OP_EWEN:  dec_frame = {HDR_EWXX, EWEN_SUBCODE, {(ADDR_BITS - 2 + DATA_BITS){1'b0}}};
         default:  dec_frame = {HDR_EWXX, {(ADDR_BITS + DATA_BITS){1'b0}}};
      endcase
   end

   // Two-entry queue toward the sequencer.
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_ctl      = ctl_ff[rd_ptr_ff];
   assign q_frame    = frame_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= dec_ctl;
         frame_ff[wr_ptr_ff] <= dec_frame;
      end
   end

`ifndef SYNTHESIS
   // The fill level never passes the queue depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("front queue over full");

   // Pointers that differ mean exactly one entry is held.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) |-> (count_ff == 2'd1))
      else $error("front queue pointers and count disagree");

   // With both slots taken no further beat is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("push into a full front queue");
`endif

endmodule

>>> sv/mwe_back.sv
module mwe_back
   import mwe_pkg::*;
#(
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic q_valid,
   output logic q_ready,
   input  ctl_type q_ctl,
   input  logic [3 + ADDR_BITS + DATA_BITS - 1:0] q_frame,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: chip_select, mosi, clock_pulse, busy_res,
   // refused, rdata_valid, rdata, zero fill.
   output logic [((RSP_FLAG_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int HDR_BITS   = 3 + ADDR_BITS;
   localparam int FRAME_BITS = HDR_BITS + DATA_BITS;
   localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);
   localparam int RSP_BITS   = ((RSP_FLAG_BITS + DATA_BITS + 7) / 8) * 8;

   localparam logic [CNT_BITS-1:0] HDR_LEN   = CNT_BITS'(HDR_BITS);
   localparam logic [CNT_BITS-1:0] FRAME_LEN = CNT_BITS'(FRAME_BITS);

   phase_type              phase_ff, phase_in;
   logic [CNT_BITS-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;
   logic [DATA_BITS-1:0]   in_shift_ff, in_shift_in;
   logic [WAIT_BITS-1:0]   wait_ff, wait_in;
   op_type                 op_ff, op_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_flags_type          rsp_flags_ff, flags;
   logic [DATA_BITS-1:0]   rsp_rdata_ff, rdata;

   logic                   pop;
   logic [CNT_BITS-1:0]    frame_len;
   logic [CNT_BITS-1:0]    cnt_next;

   // An item is taken whenever the result register is free or drains now.
   assign q_ready = !rsp_valid_ff || rsp_tready;
   assign pop     = q_valid && q_ready;

   assign frame_len = ((op_ff == OP_READ) || (op_ff == OP_WRITE)) ? FRAME_LEN : HDR_LEN;
   assign cnt_next  = bit_cnt_ff + 1'b1;

   // Sequencer step for one item.
   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      in_shift_in = in_shift_ff;
      wait_in     = wait_ff;
      op_in       = op_ff;
      flags       = '0;
      rdata       = '0;

      if (q_ctl.kind == KIND_START) begin
         if (phase_ff != PH_IDLE) begin
            flags.refused = 1'b1;
         end else begin
            op_in       = q_ctl.op;
            shift_in    = q_frame;
            in_shift_in = '0;
            bit_cnt_in  = '0;
            wait_in     = '0;
            phase_in    = PH_SHIFT;
         end
      end else begin
         unique case (phase_ff)
            PH_SHIFT: begin
               flags.chip_select = 1'b1;
               flags.clock_pulse = 1'b1;
               flags.mosi        = shift_ff[FRAME_BITS-1];
               shift_in          = {shift_ff[FRAME_BITS-2:0], 1'b0};
               if ((op_ff == OP_READ) && (bit_cnt_ff >= HDR_LEN)) begin
                  in_shift_in = {in_shift_ff[DATA_BITS-2:0], q_ctl.miso};
               end
               bit_cnt_in = cnt_next;
               if (cnt_next == frame_len) begin
                  bit_cnt_in = '0;
                  if (op_ff == OP_READ) begin
                     flags.rdata_valid = 1'b1;
                     rdata             = in_shift_in;
                  end
                  wait_in  = (op_ff == OP_WRITE) ? cfg.write_wait_ticks : cfg.settle_ticks;
                  phase_in = (wait_in == '0) ? PH_IDLE : PH_SETTLE;
               end
            end
            PH_SETTLE: begin
               if (wait_ff != '0) begin
                  wait_in = wait_ff - 1'b1;
               end
               if (wait_in == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      flags.busy_res = (phase_in != PH_IDLE);
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);

   // Control state of the sequencer and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         in_shift_ff  <= '0;
         wait_ff      <= '0;
         op_ff        <= OP_READ;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            bit_cnt_ff  <= bit_cnt_in;
            shift_ff    <= shift_in;
            in_shift_ff <= in_shift_in;
            wait_ff     <= wait_in;
            op_ff       <= op_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded with each processed item.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_flags_ff <= flags;
         rsp_rdata_ff <= rdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_rdata_ff, rsp_flags_ff});

`ifndef SYNTHESIS
   // While a frame runs the bit count stays inside the frame.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SHIFT) |-> (bit_cnt_ff < frame_len))
      else $error("bit counter ran past the frame");

   // The settle phase is only held with ticks left to wait.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SETTLE) |-> (wait_ff != '0))
      else $error("settle phase with an empty wait counter");

   // A read byte is only shown together with its valid flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_rdata_ff != '0)) |-> rsp_flags_ff.rdata_valid)
      else $error("read data without valid flag");

   // Outside a frame the counter rests at zero.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SHIFT) |-> (bit_cnt_ff == '0))
      else $error("bit counter not cleared after a frame");
`endif

endmodule

>>> sv/microwire_eeprom_master.sv
// Microwire master for a byte-organised serial EEPROM. A beat with cmd 0
// starts an operation (read, write, write enable, write disable) on the given
// address and byte; each beat with cmd 1 is one serial bit time and returns
// the chip select, data out and clock pulse levels for that bit, plus the
// busy, refused and read-byte status. A frame is a start bit, two opcode bits
// and the address, followed by the data byte for read and write; after it
// chip select drops and a settle wait of settle_ticks (or write_wait_ticks
// after a write) tick beats runs before the next start is taken. Every
// request beat yields exactly one response beat. The block takes one beat per
// clock while the response side takes results; a stall there holds the flow.
// A two-entry queue decouples request decoding from the bit sequencer, and the
// sequencer updates its state once per beat, so the rate is set by the state
// update and by how fast responses are taken. A request beat is held in a queue
// entry and then in the result register before its response beat is offered.
module microwire_eeprom_master
   import mwe_pkg::*;
#(
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: op, addr, wdata, miso, zero fill.
   input  logic [((3 + ADDR_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0 up: cmd.
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: chip_select, mosi, clock_pulse, busy_res,
   // refused, rdata_valid, rdata, zero fill.
   output logic [((RSP_FLAG_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WAIT_BITS-1:0] csr_wdata
);

   localparam int FRAME_BITS = 3 + ADDR_BITS + DATA_BITS;

   logic                   q_valid;
   logic                   q_ready;
   ctl_type                q_ctl;
   logic [FRAME_BITS-1:0]  q_frame;
   cfg_type                cfg_ff, cfg_in;

   // Wait registers; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_SETTLE_TICKS) begin
            cfg_in.settle_ticks = csr_wdata;
         end else if (csr_index == REG_WRITE_WAIT_TICKS) begin
            cfg_in.write_wait_ticks = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks     <= SETTLE_TICKS_RESET;
         cfg_ff.write_wait_ticks <= WRITE_WAIT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mwe_front #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_ctl      (q_ctl),
      .q_frame    (q_frame)
   );

   mwe_back #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_ctl      (q_ctl),
      .q_frame    (q_frame),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import mwe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W = 7;
   localparam int DATA_W = 8;
   localparam int HDR_W = 3 + ADDR_W;
   localparam int FRAME_W = HDR_W + DATA_W;
   localparam int REQ_W = ((3 + ADDR_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_W = ((RSP_FLAG_BITS + DATA_W + 7) / 8) * 8;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 125;

   // One result beat: the read byte above the flags, as it sits in rsp_tdata.
   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      rsp_flags_type     flags;
   } wire_beat_type;

   // Directed stimulus row; ticks may be repeated.
   typedef struct {
      item_kind_type     kind;
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              miso;
      int                reps;
      bit                typed;
      wire_beat_type     want;
   } dir_row_type;

   localparam wire_beat_type BEAT_QUIET   = '0;
   localparam wire_beat_type BEAT_BUSY    = {8'h00, 6'b001000};
   localparam wire_beat_type BEAT_REFUSED = {8'h00, 6'b011000};
   localparam int DIR_ROWS = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [WAIT_BITS-1:0] csr_wdata = '0;

   // Predicted sequencer state and register copies.
   phase_type             seq_phase;
   op_type                cur_op;
   logic [FRAME_W-1:0]    seq_frame;
   logic [DATA_W-1:0]     rd_byte;
   logic [WAIT_BITS-1:0]  settle_left;
   int unsigned           seq_bits;
   logic [WAIT_BITS-1:0]  cfg_settle;
   logic [WAIT_BITS-1:0]  cfg_write_wait;

   wire_beat_type wire_beat_q [$];
   wire_beat_type want_beat;
   wire_beat_type got_beat;
   int err_cnt = 0;
   int stall_cnt = 0;
   bit idle_on = 1'b1;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 1,  1'b1, BEAT_QUIET},
      '{KIND_START, OP_READ,  7'd127, 8'hFF, 1'b1, 1,  1'b1, BEAT_BUSY},
      '{KIND_START, OP_EWDS,  7'd0,   8'h00, 1'b0, 1,  1'b1, BEAT_REFUSED},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 18, 1'b0, BEAT_QUIET},
      '{KIND_START, OP_WRITE, 7'd5,   8'h5A, 1'b1, 1,  1'b1, BEAT_REFUSED},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 1,  1'b0, BEAT_QUIET},
      '{KIND_TICK,  OP_WRITE, 7'd127, 8'hFF, 1'b1, 1,  1'b1, BEAT_QUIET},
      '{KIND_START, OP_READ,  7'd0,   8'h00, 1'b0, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b0, 19, 1'b0, BEAT_QUIET},
      '{KIND_START, OP_WRITE, 7'd127, 8'hFF, 1'b1, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 33, 1'b0, BEAT_QUIET},
      '{KIND_START, OP_WRITE, 7'd0,   8'h00, 1'b0, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b0, 33, 1'b0, BEAT_QUIET},
      '{KIND_START, OP_EWEN,  7'd127, 8'hFF, 1'b1, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 11, 1'b0, BEAT_QUIET},
      '{KIND_START, OP_EWDS,  7'd127, 8'hFF, 1'b1, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b0, 5,  1'b0, BEAT_QUIET},
      '{KIND_START, OP_EWEN,  7'd3,   8'h3C, 1'b0, 1,  1'b1, BEAT_REFUSED},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 6,  1'b0, BEAT_QUIET},
      '{KIND_START, OP_READ,  7'd42,  8'hC3, 1'b0, 1,  1'b1, BEAT_BUSY},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 10, 1'b0, BEAT_QUIET},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b0, 4,  1'b0, BEAT_QUIET},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 4,  1'b0, BEAT_QUIET},
      '{KIND_TICK,  OP_READ,  7'd0,   8'h00, 1'b1, 2,  1'b0, BEAT_QUIET}
   };

   microwire_eeprom_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side stalls at random unless idling is switched off.
   always @(negedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 14);
   end

   // Works out the line levels and status for one item and advances the state.
   function automatic wire_beat_type predict_wire_beat(input item_kind_type kind,
                                                       input op_type op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [DATA_W-1:0] wdata,
                                                       input logic miso);
      wire_beat_type r;
      int unsigned len;
      r = '0;
      if (kind == KIND_START) begin
         if (seq_phase != PH_IDLE) begin
            r.flags.refused = 1'b1;
         end else begin
            cur_op = op;
            // The frame is kept left-aligned so the next bit is always the top one.
            case (op)
               OP_READ:  seq_frame = {HDR_READ, addr, {DATA_W{1'b0}}};
               OP_WRITE: seq_frame = {HDR_WRITE, addr, wdata};
               OP_EWEN:  seq_frame = {HDR_EWXX, EWEN_SUBCODE, {(ADDR_W-2){1'b0}},
                                      {DATA_W{1'b0}}};
               default:  seq_frame = {HDR_EWXX, {ADDR_W{1'b0}}, {DATA_W{1'b0}}};
            endcase
            rd_byte = '0;
            seq_bits = 0;
            settle_left = '0;
            seq_phase = PH_SHIFT;
         end
      end else if (seq_phase == PH_SHIFT) begin
         len = (cur_op == OP_READ || cur_op == OP_WRITE) ? FRAME_W : HDR_W;
         r.flags.chip_select = 1'b1;
         r.flags.clock_pulse = 1'b1;
         r.flags.mosi = seq_frame[FRAME_W-1];
         seq_frame = seq_frame << 1;
         // Only the data bits of a read are collected.
         if (cur_op == OP_READ && seq_bits >= HDR_W) begin
            rd_byte = {rd_byte[DATA_W-2:0], miso};
         end
         seq_bits = seq_bits + 1;
         if (seq_bits == len) begin
            seq_bits = 0;
            if (cur_op == OP_READ) begin
               r.flags.rdata_valid = 1'b1;
               r.rdata = rd_byte;
            end
            settle_left = (cur_op == OP_WRITE) ? cfg_write_wait : cfg_settle;
            seq_phase = (settle_left == 0) ? PH_IDLE : PH_SETTLE;
         end
      end else if (seq_phase == PH_SETTLE) begin
         if (settle_left != 0) begin
            settle_left = settle_left - 1'b1;
         end
         if (settle_left == 0) begin
            seq_phase = PH_IDLE;
         end
      end
      r.flags.busy_res = (seq_phase != PH_IDLE);
      return r;
   endfunction

   // Sends one request beat; entered and left at a falling edge.
   task automatic send_item(input item_kind_type kind, input op_type op,
                            input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, input logic miso,
                            input bit typed, input wire_beat_type want);
      wire_beat_type predicted;
      while (idle_on && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_W-3-ADDR_W-DATA_W){1'b0}}, miso, wdata, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_wire_beat(kind, op, addr, wdata, miso);
      wire_beat_q.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Writes one register; entered and left at a falling edge.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [WAIT_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SETTLE_TICKS) begin
         cfg_settle = val;
      end else if (idx == REG_WRITE_WAIT_TICKS) begin
         cfg_write_wait = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected beat has come back.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (wire_beat_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Mostly whole transactions with random content, plus idle ticks and
   // starts that land while the sequencer is busy.
   task automatic run_random(input int n_items);
      int n_done;
      op_type rop;
      n_done = 0;
      while (n_done < n_items) begin
         rop = op_type'($urandom_range(3));
         if (seq_phase == PH_IDLE) begin
            if ($urandom_range(99) < 88) begin
               send_item(KIND_START, rop, ADDR_W'($urandom_range(127)),
                         DATA_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
               n_done++;
            end else begin
               send_item(KIND_TICK, rop, ADDR_W'($urandom_range(127)),
                         DATA_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            end
         end else if ($urandom_range(99) < 4) begin
            send_item(KIND_START, rop, ADDR_W'($urandom_range(127)),
                      DATA_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            send_item(KIND_TICK, rop, ADDR_W'($urandom_range(127)),
                      DATA_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            n_done++;
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_cnt++;
      end
   endtask

   // Compares each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (wire_beat_q.size() == 0) begin
            $error("result beat arrived with nothing expected");
            err_cnt++;
         end else begin
            want_beat = wire_beat_q.pop_front();
            got_beat = rsp_tdata[RSP_FLAG_BITS+DATA_W-1:0];
            check_field("chip_select", want_beat.flags.chip_select,
                        got_beat.flags.chip_select);
            check_field("mosi", want_beat.flags.mosi, got_beat.flags.mosi);
            check_field("clock_pulse", want_beat.flags.clock_pulse,
                        got_beat.flags.clock_pulse);
            check_field("busy_res", want_beat.flags.busy_res, got_beat.flags.busy_res);
            check_field("refused", want_beat.flags.refused, got_beat.flags.refused);
            check_field("rdata_valid", want_beat.flags.rdata_valid,
                        got_beat.flags.rdata_valid);
            check_field("rdata", want_beat.rdata, got_beat.rdata);
         end
      end
   end

   // Ends the run if no channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   initial begin
      logic [WAIT_BITS-1:0] s_val;
      logic [WAIT_BITS-1:0] w_val;
      seq_phase = PH_IDLE;
      cur_op = OP_READ;
      seq_frame = '0;
      rd_byte = '0;
      settle_left = '0;
      seq_bits = 0;
      cfg_settle = SETTLE_TICKS_RESET;
      cfg_write_wait = WRITE_WAIT_TICKS_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset register values.
      foreach (dir_rows[i]) begin
         for (int r = 0; r < dir_rows[i].reps; r++) begin
            send_item(dir_rows[i].kind, dir_rows[i].op, dir_rows[i].addr,
                      dir_rows[i].wdata, dir_rows[i].miso, dir_rows[i].typed,
                      dir_rows[i].want);
         end
      end

      // Random phases, each under its own wait settings; one runs without idling.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_pipe();
         case (ph)
            0: begin
               s_val = 8'h00;
               w_val = 8'h00;
            end
            1: begin
               s_val = 8'hFF;
               w_val = 8'hFF;
            end
            default: begin
               s_val = WAIT_BITS'($urandom_range(4));
               w_val = WAIT_BITS'($urandom_range(24));
            end
         endcase
         if ($urandom_range(1) == 0) begin
            write_reg(REG_SETTLE_TICKS, s_val);
            write_reg(REG_WRITE_WAIT_TICKS, w_val);
         end else begin
            write_reg(REG_WRITE_WAIT_TICKS, w_val);
            write_reg(REG_SETTLE_TICKS, s_val);
         end
         // An index past the last register must leave both untouched.
         write_reg(CSR_INDEX_BITS'($urandom_range(255, 2)), WAIT_BITS'($urandom_range(255)));
         idle_on = (ph != 3);
         run_random(PHASE_ITEMS);
      end

      idle_on = 1'b1;
      drain_pipe();
      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
